>>> design/cpts_pkg.sv
// shared types and constants for the counter/priority task scheduler
// command and status structs between controller and datapath, state encoding
// no dependencies
package cpts_pkg;

  localparam int CNT_W       = 8;
  localparam int TASK_IN_W   = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // input word layout
  localparam int IN_IDX_LO  = 0;
  localparam int IN_PRIO_LO = 4;
  localparam int IN_RUN_BIT = 12;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  typedef struct packed {
    logic capture;
    logic set_wr;
    logic dec;
    logic sweep_init;
    logic scan;
    logic reload;
    logic commit_best;
    logic commit_idle;
    logic out_load;
  } cpts_cmd_t;

  typedef struct packed {
    logic cur_zero;
    logic dec_zero;
    logic sweep_done;
    logic pick_ok;
    logic reloaded;
  } cpts_sts_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SET    = 8'b0000_0010,
    S_TRD    = 8'b0000_0100,
    S_TCHK   = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_RELOAD = 8'b0010_0000,
    S_RDCUR  = 8'b0100_0000,
    S_CAP    = 8'b1000_0000
  } cpts_state_t;

endpackage

>>> design/cpts_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module cpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/cpts_ctrl.sv
// controller state machine of the task scheduler
// depends on cpts_pkg; drives commands into cpts_dp and owns the output valid
module cpts_ctrl import cpts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_func,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  cpts_sts_t sts,
  output cpts_cmd_t cmd
);

  cpts_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_func == FUNC_SET) ? S_SET : S_TRD;
        end
      end
      S_SET: begin
        cmd.set_wr = 1'b1;
        state_nxt  = S_RDCUR;
      end
      S_TRD: begin
        state_nxt = S_TCHK;
      end
      S_TCHK: begin
        if (sts.cur_zero) begin
          cmd.sweep_init = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.dec = 1'b1;
          if (sts.dec_zero) begin
            cmd.sweep_init = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_RDCUR;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.sweep_done) begin
          priority if (sts.pick_ok) begin
            cmd.commit_best = 1'b1;
            state_nxt       = S_RDCUR;
          end else if (!sts.reloaded) begin
            cmd.sweep_init = 1'b1;
            state_nxt      = S_RELOAD;
          end else begin
            // nothing worth running even after reload: fall back to idle
            cmd.commit_idle = 1'b1;
            state_nxt       = S_RDCUR;
          end
        end
      end
      S_RELOAD: begin
        cmd.reload = 1'b1;
        if (sts.sweep_done) begin
          cmd.sweep_init = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_RDCUR: begin
        state_nxt = S_CAP;
      end
      S_CAP: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/cpts_dp.sv
// datapath of the task scheduler: priority and counter rams, runnable flags,
// scan/reload sweep, best-pick registers and output word; depends on cpts_pkg, cpts_ram
module cpts_dp import cpts_pkg::*; #(
  parameter int TASKS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  cpts_cmd_t              cmd,
  output cpts_sts_t              sts,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int IDX_W = $clog2(TASKS);
  localparam int SW_W  = IDX_W + 1;
  localparam int RNG_W = 8;

  // latched input word
  logic [IDX_W-1:0] f_idx_r;
  logic             f_inrange_r;
  logic [CNT_W-1:0] f_prio_r;
  logic             f_run_r;

  logic [IDX_W-1:0] running_r, running_nxt;
  logic [IDX_W-1:0] before_r;
  logic [TASKS-1:0] runnable_r, runnable_nxt;
  logic [TASKS-1:0] prio_vld_r, prio_vld_nxt;
  logic [TASKS-1:0] cnt_vld_r, cnt_vld_nxt;

  logic [SW_W-1:0]  sw_i_r, sw_i_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] best_cnt_r, best_cnt_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             reloaded_r, reloaded_nxt;
  logic             cnt_rvld_r, prio_rvld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic             issue_done;
  logic [IDX_W-1:0] sw_idx;
  logic [IDX_W-1:0] cnt_raddr;
  logic             cnt_we;
  logic [IDX_W-1:0] cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic [CNT_W-1:0] cnt_rdata, prio_rdata;
  logic [CNT_W-1:0] cnt_cur, prio_cur;
  logic             sweep_step;
  logic [TASK_IN_W-1:0] in_idx;

  assign in_idx     = in_data[IN_IDX_LO +: TASK_IN_W];
  assign issue_done = (sw_i_r == SW_W'(TASKS));
  assign sw_idx     = sw_i_r[IDX_W-1:0];
  assign sweep_step = cmd.scan || cmd.reload;

  // entries never written read as zero
  assign cnt_cur  = cnt_rdata & {CNT_W{cnt_rvld_r}};
  assign prio_cur = prio_rdata & {CNT_W{prio_rvld_r}};

  // counter ram reads the sweep slot while scanning, the running slot otherwise
  assign cnt_raddr = (cmd.scan && !issue_done) ? sw_idx : running_r;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = running_r;
    cnt_wdata = '0;
    priority if (cmd.set_wr && f_inrange_r) begin
      cnt_we    = 1'b1;
      cnt_waddr = f_idx_r;
    end else if (cmd.dec) begin
      cnt_we    = 1'b1;
      cnt_wdata = cnt_cur - CNT_W'(1);
    end else if (cmd.reload && pend_r) begin
      cnt_we    = 1'b1;
      cnt_waddr = pend_idx_r;
      cnt_wdata = prio_cur;
    end else begin
      cnt_we = 1'b0;
    end
  end

  cpts_ram #(.WIDTH(CNT_W), .DEPTH(TASKS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  cpts_ram #(.WIDTH(CNT_W), .DEPTH(TASKS)) u_prio_ram (
    .clk   (clk),
    .we    (cmd.set_wr && f_inrange_r),
    .waddr (f_idx_r),
    .wdata (f_prio_r),
    .raddr (sw_idx),
    .rdata (prio_rdata)
  );

  always_comb begin
    running_nxt  = running_r;
    runnable_nxt = runnable_r;
    prio_vld_nxt = prio_vld_r;
    cnt_vld_nxt  = cnt_vld_r;
    sw_i_nxt     = sw_i_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    found_nxt    = found_r;
    best_cnt_nxt = best_cnt_r;
    best_idx_nxt = best_idx_r;
    reloaded_nxt = reloaded_r;

    if (cmd.capture) begin
      reloaded_nxt = 1'b0;
    end
    if (cmd.set_wr && f_inrange_r) begin
      runnable_nxt[f_idx_r] = f_run_r;
      prio_vld_nxt[f_idx_r] = 1'b1;
    end
    if (cnt_we) begin
      cnt_vld_nxt[cnt_waddr] = 1'b1;
    end
    if (cmd.reload) begin
      reloaded_nxt = 1'b1;
    end

    if (sweep_step) begin
      if (!issue_done) begin
        sw_i_nxt     = sw_i_r + SW_W'(1);
        pend_nxt     = 1'b1;
        pend_idx_nxt = sw_idx;
      end else begin
        pend_nxt = 1'b0;
      end
    end

    // strict greater-than keeps the lowest index on ties
    if (cmd.scan && pend_r && runnable_r[pend_idx_r] &&
        (!found_r || (cnt_cur > best_cnt_r))) begin
      found_nxt    = 1'b1;
      best_cnt_nxt = cnt_cur;
      best_idx_nxt = pend_idx_r;
    end

    if (cmd.sweep_init) begin
      sw_i_nxt     = '0;
      pend_nxt     = 1'b0;
      found_nxt    = 1'b0;
      best_cnt_nxt = '0;
      best_idx_nxt = '0;
    end

    if (cmd.commit_best) begin
      running_nxt = best_idx_r;
    end else if (cmd.commit_idle) begin
      running_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= '0;
      runnable_r <= TASKS'(1);
      prio_vld_r <= '0;
      cnt_vld_r  <= '0;
      sw_i_r     <= '0;
      pend_r     <= 1'b0;
      found_r    <= 1'b0;
      reloaded_r <= 1'b0;
    end else begin
      running_r  <= running_nxt;
      runnable_r <= runnable_nxt;
      prio_vld_r <= prio_vld_nxt;
      cnt_vld_r  <= cnt_vld_nxt;
      sw_i_r     <= sw_i_nxt;
      pend_r     <= pend_nxt;
      found_r    <= found_nxt;
      reloaded_r <= reloaded_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_idx_r  <= pend_idx_nxt;
    best_cnt_r  <= best_cnt_nxt;
    best_idx_r  <= best_idx_nxt;
    cnt_rvld_r  <= cnt_vld_r[cnt_raddr];
    prio_rvld_r <= prio_vld_r[sw_idx];
    if (cmd.capture) begin
      f_idx_r     <= IDX_W'(in_idx);
      f_inrange_r <= (RNG_W'(in_idx) < RNG_W'(TASKS));
      f_prio_r    <= in_data[IN_PRIO_LO +: CNT_W];
      f_run_r     <= in_data[IN_RUN_BIT];
      before_r    <= running_r;
    end
    if (cmd.out_load) begin
      out_data_r <= {2'b00, reloaded_r, (running_r != before_r), cnt_cur,
                     TASK_IN_W'(running_r)};
    end
  end

  assign out_data = out_data_r;

  assign sts.cur_zero   = (running_r == '0) || (cnt_cur == '0);
  assign sts.dec_zero   = (cnt_cur == CNT_W'(1));
  assign sts.sweep_done = issue_done && !pend_r;
  assign sts.pick_ok    = found_r && (best_cnt_r != '0);
  assign sts.reloaded   = reloaded_r;

endmodule

>>> design/counter_priority_task_scheduler_top.sv
// top level of the counter/priority task scheduler
// depends on cpts_pkg, cpts_ctrl, cpts_dp (which holds two cpts_ram)
//
//   channel | ports                                | contents
//   --------+--------------------------------------+--------------------------------
//   in      | in_tvalid in_tready in_tdata in_tuser | set-task or timer tick word
//   out     | out_tvalid out_tready out_tdata      | running task and slice counter
//
// one word at a time; a tick that reschedules runs one scan sweep over all slots, and one
// that reloads runs a scan sweep, a reload sweep and a second scan sweep
// (each sweep reads one slot per cycle through the counter or priority ram read port)
// reset is synchronous, active low, and takes effect at once: no clearing pass
// a new word is taken while the last result still waits in the output register
module counter_priority_task_scheduler_top import cpts_pkg::*; #(
  parameter int TASKS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [3:0] task_index, [11:4] priority_req, [12] runnable, [15:13] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [3:0] current_task, [11:4] current_count, [12] switched, [13] reloaded, [15:14] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cpts_cmd_t cmd;
  cpts_sts_t sts;

  cpts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_func   (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpts_dp #(.TASKS(TASKS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule
